### src/i2cmts_pkg.sv
// Shared types and constants for the I2C master transfer sequencer.
// Depends on nothing; every other file in src uses it by scoped names.
package i2cmts_pkg;

	// Result queue depth default; must be at least two.
	localparam int unsigned ResDepth = 4;

	// Timeout register width and reset value.
	localparam int unsigned TimeoutW = 20;
	localparam logic [TimeoutW-1:0] TimeoutReset = 20'd200000;

	// Address byte masks for the direction bit.
	localparam logic [7:0] AddrWrMask = 8'hfe;
	localparam logic [7:0] AddrRdBit  = 8'h01;

	// Request kinds on the input channel.
	typedef enum logic [1:0] {
		REQ_BEGIN = 2'd0,
		REQ_BYTE  = 2'd1,
		REQ_EVENT = 2'd2,
		REQ_TICK  = 2'd3
	} req_t;

	// Transfer kinds.
	typedef enum logic [1:0] {
		KIND_WRITE = 2'd0,
		KIND_READ  = 2'd1,
		KIND_PROBE = 2'd2
	} kind_t;

	localparam logic [1:0] OpProbeAlias = 2'd3;

	// Engine status codes, renumbered densely.
	localparam logic [3:0] EvStart    = 4'd0;
	localparam logic [3:0] EvRstart   = 4'd1;
	localparam logic [3:0] EvSlawAck  = 4'd2;
	localparam logic [3:0] EvSlarAck  = 4'd3;
	localparam logic [3:0] EvDatawAck = 4'd4;
	localparam logic [3:0] EvDatarAck = 4'd5;
	localparam logic [3:0] EvDatarNak = 4'd6;
	localparam logic [3:0] EvOther    = 4'd7;
	localparam logic [3:0] EvStopDone = 4'd8;

	// Sequencer phases.
	typedef enum logic [3:0] {
		PH_IDLE   = 4'd0,
		PH_START  = 4'd1,
		PH_ADDR   = 4'd2,
		PH_NEEDB  = 4'd3,
		PH_DATW   = 4'd4,
		PH_RSTART = 4'd5,
		PH_RADDR  = 4'd6,
		PH_DATR   = 4'd7,
		PH_STOP   = 4'd8
	} phase_t;

	// Result actions.
	typedef enum logic [3:0] {
		ACT_START   = 4'd0,
		ACT_RSTART  = 4'd1,
		ACT_SEND    = 4'd2,
		ACT_NEED    = 4'd3,
		ACT_RACK    = 4'd4,
		ACT_RNACK   = 4'd5,
		ACT_DELIVER = 4'd6,
		ACT_STOP    = 4'd7,
		ACT_DONE    = 4'd8
	} action_t;

	// Input item.
	typedef struct packed {
		logic [1:0]  req_type;
		logic [1:0]  op;
		logic [7:0]  slave_addr;
		logic [7:0]  header_len;
		logic [15:0] data_len;
		logic [7:0]  tx_byte;
		logic [3:0]  event_code;
		logic [7:0]  rx_byte;
	} req_item_t;

	// Result item.
	typedef struct packed {
		logic [3:0] action;
		logic [7:0] out_byte;
		logic       status;
		logic       last;
	} res_item_t;

	// Results produced by one accepted item, handed to the queue.
	typedef struct packed {
		logic [1:0] n;
		res_item_t  r0;
		res_item_t  r1;
	} res_push_t;

endpackage

### src/i2c_master_transfer_sequencer_core.sv
// Top level of the I2C master transfer sequencer.
// Instantiates i2cmts_fsm and i2cmts_res_fifo; uses i2cmts_pkg.
//
//  channel  | signals                       | direction | payload
//  ---------+-------------------------------+-----------+---------------------
//  request  | req_valid, req_ready, req     | in        | i2cmts_pkg::req_item_t
//  result   | res_valid, res_ready, res     | out       | i2cmts_pkg::res_item_t
//  config   | cfg_we, cfg_wdata             | in        | timeout_limit, 20 bit
//
// A request is handled in the cycle it is accepted; its zero, one or two results
// are visible on the result channel from the next cycle, one transfer per cycle
// while res_ready is high. req_ready is high while the result queue has room for
// two results, so one request per cycle is taken as long as results drain at the
// rate they arrive. A stalled result channel fills the queue and then holds off
// requests. Reset (arst_n low) returns to idle with the timeout limit at 200000.
module i2c_master_transfer_sequencer_core #(
	parameter int unsigned RES_DEPTH = i2cmts_pkg::ResDepth
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             req_valid,
	output logic                             req_ready,
	input  i2cmts_pkg::req_item_t            req,
	output logic                             res_valid,
	input  logic                             res_ready,
	output i2cmts_pkg::res_item_t            res,
	input  logic                             cfg_we,
	input  logic [i2cmts_pkg::TimeoutW-1:0]  cfg_wdata
);

	i2cmts_pkg::res_push_t push;
	logic                  accept;

	assign accept = req_valid && req_ready;

	// Sequencer
	i2cmts_fsm u_fsm (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.push      (push)
	);

	// Result queue
	i2cmts_res_fifo #(
		.DEPTH (RES_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (req_ready),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// Once results are written, the queue offers a result next cycle
	a_push_shows: assert property (@(posedge clk) disable iff (!arst_n)
		(push.n != 2'd0) |=> res_valid)
		else $error("queued result not offered");

	// Only the final result of a pair is marked last
	a_pair_last: assert property (@(posedge clk) disable iff (!arst_n)
		(push.n == 2'd2) |-> (push.r1.last && !push.r0.last))
		else $error("last mark wrong on result pair");

	// A single result is always last
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		(push.n == 2'd1) |-> push.r0.last)
		else $error("single result not marked last");

	// Requests are held off only while results are waiting
	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		!req_ready |-> res_valid)
		else $error("request held off with empty queue");

endmodule

### src/i2cmts_fsm.sv
// Transfer sequencer state machine: phase, counters and timeout register.
// Produces up to two results per accepted item. Uses i2cmts_pkg.
module i2cmts_fsm (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                accept,
	input  i2cmts_pkg::req_item_t               req,
	input  logic                                cfg_we,
	input  logic [i2cmts_pkg::TimeoutW-1:0]     cfg_wdata,
	output i2cmts_pkg::res_push_t               push
);

	i2cmts_pkg::phase_t phase_q, phase_d;
	i2cmts_pkg::kind_t  kind_q, kind_d;
	logic [7:0]  addr_q, addr_d;
	logic [7:0]  hdr_q, hdr_d;
	logic [15:0] data_q, data_d;
	logic        failed_q, failed_d;
	logic [i2cmts_pkg::TimeoutW-1:0] wait_q, wait_d;
	logic [i2cmts_pkg::TimeoutW-1:0] limit_q;

	logic [15:0] data_dec;
	logic        is_start;
	logic        wack_more;
	logic [3:0]  a0, a1;
	logic [7:0]  b0, b1;
	logic        s0;
	logic [1:0]  n;

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= i2cmts_pkg::PH_IDLE;
			kind_q   <= i2cmts_pkg::KIND_WRITE;
			addr_q   <= '0;
			hdr_q    <= '0;
			data_q   <= '0;
			failed_q <= 1'b0;
			wait_q   <= '0;
		end else if (accept) begin
			phase_q  <= phase_d;
			kind_q   <= kind_d;
			addr_q   <= addr_d;
			hdr_q    <= hdr_d;
			data_q   <= data_d;
			failed_q <= failed_d;
			wait_q   <= wait_d;
		end
	end

	// Timeout limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= i2cmts_pkg::TimeoutReset;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	assign data_dec  = data_q - 16'd1;
	assign is_start  = (req.event_code == i2cmts_pkg::EvStart) ||
	                   (req.event_code == i2cmts_pkg::EvRstart);
	// more bytes to request after a write-direction ack
	assign wack_more = (hdr_q != 8'd0) ||
	                   ((kind_q == i2cmts_pkg::KIND_WRITE) && (data_q != 16'd0));

	// Next state and results
	always_comb begin
		phase_d  = phase_q;
		kind_d   = kind_q;
		addr_d   = addr_q;
		hdr_d    = hdr_q;
		data_d   = data_q;
		failed_d = failed_q;
		wait_d   = wait_q;
		n  = 2'd0;
		a0 = i2cmts_pkg::ACT_START;
		b0 = 8'd0;
		s0 = 1'b0;
		a1 = i2cmts_pkg::ACT_START;
		b1 = 8'd0;
		unique case (i2cmts_pkg::req_t'(req.req_type))
			i2cmts_pkg::REQ_BEGIN: begin
				if (phase_q == i2cmts_pkg::PH_IDLE) begin
					kind_d   = (req.op == i2cmts_pkg::OpProbeAlias) ?
					           i2cmts_pkg::KIND_PROBE : i2cmts_pkg::kind_t'(req.op);
					addr_d   = req.slave_addr;
					hdr_d    = req.header_len;
					data_d   = req.data_len;
					failed_d = 1'b0;
					phase_d  = i2cmts_pkg::PH_START;
					wait_d   = '0;
					n  = 2'd1;
					a0 = i2cmts_pkg::ACT_START;
				end
			end
			i2cmts_pkg::REQ_BYTE: begin
				if (phase_q == i2cmts_pkg::PH_NEEDB) begin
					if (hdr_q != 8'd0) hdr_d = hdr_q - 8'd1;
					else data_d = data_dec;
					phase_d = i2cmts_pkg::PH_DATW;
					wait_d  = '0;
					n  = 2'd1;
					a0 = i2cmts_pkg::ACT_SEND;
					b0 = req.tx_byte;
				end
			end
			i2cmts_pkg::REQ_EVENT: begin
				// default outcome for any phase but idle and stop: fail and stop
				if (phase_q != i2cmts_pkg::PH_IDLE && phase_q != i2cmts_pkg::PH_STOP) begin
					failed_d = 1'b1;
					phase_d  = i2cmts_pkg::PH_STOP;
					wait_d   = '0;
					n  = 2'd1;
					a0 = i2cmts_pkg::ACT_STOP;
				end
				unique case (phase_q)
					i2cmts_pkg::PH_START: begin
						if (is_start) begin
							failed_d = failed_q;
							phase_d  = i2cmts_pkg::PH_ADDR;
							a0 = i2cmts_pkg::ACT_SEND;
							b0 = addr_q & i2cmts_pkg::AddrWrMask;
						end
					end
					i2cmts_pkg::PH_ADDR, i2cmts_pkg::PH_DATW: begin
						if ((phase_q == i2cmts_pkg::PH_ADDR &&
						     req.event_code == i2cmts_pkg::EvSlawAck) ||
						    (phase_q == i2cmts_pkg::PH_DATW &&
						     req.event_code == i2cmts_pkg::EvDatawAck)) begin
							failed_d = failed_q;
							if (phase_q == i2cmts_pkg::PH_ADDR &&
							    kind_q == i2cmts_pkg::KIND_PROBE) begin
								// probe: stop right after the address ack
								a0 = i2cmts_pkg::ACT_STOP;
							end else if (wack_more) begin
								phase_d = i2cmts_pkg::PH_NEEDB;
								a0 = i2cmts_pkg::ACT_NEED;
							end else if (kind_q == i2cmts_pkg::KIND_READ) begin
								phase_d = i2cmts_pkg::PH_RSTART;
								a0 = i2cmts_pkg::ACT_RSTART;
							end else begin
								a0 = i2cmts_pkg::ACT_STOP;
							end
						end
					end
					i2cmts_pkg::PH_RSTART: begin
						if (is_start) begin
							failed_d = failed_q;
							phase_d  = i2cmts_pkg::PH_RADDR;
							a0 = i2cmts_pkg::ACT_SEND;
							b0 = addr_q | i2cmts_pkg::AddrRdBit;
						end
					end
					i2cmts_pkg::PH_RADDR: begin
						if (req.event_code == i2cmts_pkg::EvSlarAck) begin
							failed_d = failed_q;
							if (data_q != 16'd0) begin
								phase_d = i2cmts_pkg::PH_DATR;
								a0 = (data_q > 16'd1) ? i2cmts_pkg::ACT_RACK :
								     i2cmts_pkg::ACT_RNACK;
							end else begin
								// empty read
								a0 = i2cmts_pkg::ACT_STOP;
							end
						end
					end
					i2cmts_pkg::PH_DATR: begin
						if (req.event_code == i2cmts_pkg::EvDatarAck ||
						    req.event_code == i2cmts_pkg::EvDatarNak) begin
							failed_d = failed_q;
							data_d   = data_dec;
							n  = 2'd2;
							a0 = i2cmts_pkg::ACT_DELIVER;
							b0 = req.rx_byte;
							if (data_dec != 16'd0) begin
								phase_d = i2cmts_pkg::PH_DATR;
								a1 = (data_dec > 16'd1) ? i2cmts_pkg::ACT_RACK :
								     i2cmts_pkg::ACT_RNACK;
							end else begin
								a1 = i2cmts_pkg::ACT_STOP;
							end
						end
					end
					i2cmts_pkg::PH_STOP: begin
						if (req.event_code == i2cmts_pkg::EvStopDone) begin
							phase_d = i2cmts_pkg::PH_IDLE;
							wait_d  = '0;
							n  = 2'd1;
							a0 = i2cmts_pkg::ACT_DONE;
							s0 = failed_q;
						end
					end
					default: begin
						// idle or waiting for a byte request: handled above
					end
				endcase
			end
			i2cmts_pkg::REQ_TICK: begin
				if (phase_q != i2cmts_pkg::PH_IDLE && phase_q != i2cmts_pkg::PH_NEEDB) begin
					if (wait_q < limit_q) begin
						wait_d = wait_q + 1'b1;
					end else if (phase_q == i2cmts_pkg::PH_STOP) begin
						phase_d = i2cmts_pkg::PH_IDLE;
						wait_d  = '0;
						n  = 2'd1;
						a0 = i2cmts_pkg::ACT_DONE;
						s0 = failed_q;
					end else begin
						failed_d = 1'b1;
						phase_d  = i2cmts_pkg::PH_STOP;
						wait_d   = '0;
						n  = 2'd1;
						a0 = i2cmts_pkg::ACT_STOP;
					end
				end
			end
		endcase
	end

	// Results go out only for an accepted item; last marks the final one
	always_comb begin
		push.n           = accept ? n : 2'd0;
		push.r0.action   = a0;
		push.r0.out_byte = b0;
		push.r0.status   = s0;
		push.r0.last     = (n == 2'd1);
		push.r1.action   = a1;
		push.r1.out_byte = b1;
		push.r1.status   = 1'b0;
		push.r1.last     = 1'b1;
	end

endmodule

### src/i2cmts_res_fifo.sv
// Result queue: takes up to two results per cycle, hands out one per cycle while res_ready is high.
// Uses i2cmts_pkg for the result types.
module i2cmts_res_fifo #(
	parameter int unsigned DEPTH = i2cmts_pkg::ResDepth
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  i2cmts_pkg::res_push_t push,
	output logic                  room,
	output logic                  res_valid,
	input  logic                  res_ready,
	output i2cmts_pkg::res_item_t res
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] PtrLast = PW'(DEPTH - 1);
	localparam logic [CW-1:0] RoomMax = CW'(DEPTH - 2);

	i2cmts_pkg::res_item_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q, wr_ptr1, wr_ptr2;
	logic [CW-1:0] cnt_q;
	logic          pop;

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		ptr_inc = (p == PtrLast) ? '0 : p + 1'b1;
	endfunction

	assign wr_ptr1   = ptr_inc(wr_ptr_q);
	assign wr_ptr2   = ptr_inc(wr_ptr1);
	assign res_valid = (cnt_q != '0);
	assign pop       = res_valid && res_ready;
	assign room      = (cnt_q <= RoomMax);
	assign res       = mem_q[rd_ptr_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (push.n != 2'd0) mem_q[wr_ptr_q] <= push.r0;
		if (push.n == 2'd2) mem_q[wr_ptr1] <= push.r1;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push.n == 2'd1) wr_ptr_q <= wr_ptr1;
			else if (push.n == 2'd2) wr_ptr_q <= wr_ptr2;
			if (pop) rd_ptr_q <= ptr_inc(rd_ptr_q);
			cnt_q <= cnt_q + CW'(push.n) - CW'(pop);
		end
	end

endmodule
